FILE: hw/rtl/single_outstanding_command_queue_assert.svh
// assertion macros for the command queue checker
`ifndef SINGLE_OUTSTANDING_COMMAND_QUEUE_ASSERT_SVH
`define SINGLE_OUTSTANDING_COMMAND_QUEUE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SOCQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SOCQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/socq_pkg.sv
// ---------------------------------------------------------------------------
// socq_pkg
// types and constants of the single outstanding command queue
// ---------------------------------------------------------------------------
package socq_pkg;

    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_PROC  = 3'd1;
    localparam logic [2:0] OP_CMPL  = 3'd2;
    localparam logic [2:0] OP_CLRC  = 3'd3;
    localparam logic [2:0] OP_CLRA  = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    localparam logic [1:0] KIND_ISSUE  = 2'd0;
    localparam logic [1:0] KIND_NOTIFY = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] OUT_TIMEOUT = 2'd2;
    localparam logic [1:0] OUT_DISC    = 2'd3;

    localparam logic [16:0] ELAPSED_MAX = 17'h1ffff;
    localparam logic [15:0] DEFAULT_TMO_RESET = 16'd5000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  op_tag;
        logic [15:0] conn_id;
        logic [15:0] char_id;
        logic [2:0]  op_type;
        logic [15:0] tmo_req;
        logic [1:0]  result_code;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  op_tag_res;
        logic [15:0] conn_out;
        logic [15:0] char_out;
        logic [2:0]  type_out;
        logic [1:0]  outcome;
        logic        accepted;
        logic        overflow;
        logic [4:0]  queue_count;
        logic        busy_res;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] conn;
        logic [15:0] chr;
        logic [2:0]  typ;
        logic [15:0] tmo;
    } t_entry;

endpackage

FILE: hw/rtl/single_outstanding_command_queue.sv
// ---------------------------------------------------------------------------
// single_outstanding_command_queue
// queue of link operations with one in flight, timeout and flush
// ---------------------------------------------------------------------------
// each command ends in a status transfer; o_stall holds new commands off until that
//   transfer is loaded, so one command is handled at a time, and a stalled output holds it
// a flush walks the queue through the entry memory (read, then compact write back of
// the kept entries) and sends a notification for each cancelled entry
// reset clears counters, in-flight flag and timer; default timeout is 5000
module single_outstanding_command_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  socq_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output socq_pkg::t_out   o_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import socq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_WALK  = 5'b00100,
        S_INFL  = 5'b01000,
        S_STAT  = 5'b10000
    } t_state;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd;
    t_state r_st, n_st;
    t_in    r_cmd;
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_cnt, r_i, r_kept;
    logic          r_busy;
    t_entry        r_inf;
    logic [16:0]   r_el;
    logic [15:0]   r_dtmo;
    logic          r_acc, r_ovf;
    logic          r_ov;
    t_out          r_out;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    t_entry        wr_data;
    logic          out_free;
    logic          hit;
    logic          inf_end;
    logic          out_load;

    assign pready = 1'b1;
    assign prdata = {16'd0, r_dtmo};
    assign o_valid = r_ov;
    assign o_data = r_out;
    assign out_free = !r_ov || !i_stall;
    assign o_stall = (r_st != S_IDLE);

    function automatic logic [IW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] d;
        d = v - (CW+1)'(QUEUE_DEPTH);
        return (v >= (CW+1)'(QUEUE_DEPTH)) ? d[IW-1:0] : v[IW-1:0];
    endfunction

    assign rd_addr = wrap({1'b0, r_i} + {{(CW+1-IW){1'b0}}, r_head});
    assign hit = (r_cmd.opcode == OP_CLRA) || (r_rd.conn == r_cmd.conn_id);
    assign inf_end = r_busy &&
                     ((r_cmd.opcode == OP_PROC && r_el > {1'b0, r_inf.tmo}) ||
                      r_cmd.opcode == OP_CMPL ||
                      r_cmd.opcode == OP_CLRA ||
                      (r_cmd.opcode == OP_CLRC && r_inf.conn == r_cmd.conn_id));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_st = r_st;
        wr_en = 1'b0;
        out_load = 1'b0;
        wr_addr = wrap({1'b0, r_cnt} + {{(CW+1-IW){1'b0}}, r_head});
        wr_data.tag  = i_data.op_tag;
        wr_data.conn = i_data.conn_id;
        wr_data.chr  = i_data.char_id;
        wr_data.typ  = i_data.op_type;
        wr_data.tmo  = (i_data.tmo_req == 16'd0) ? r_dtmo : i_data.tmo_req;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.opcode == OP_ENQ && r_cnt < CW'(QUEUE_DEPTH)) begin
                        wr_en = 1'b1;
                    end
                    if (i_data.opcode == OP_CLRC || i_data.opcode == OP_CLRA ||
                        (i_data.opcode == OP_PROC && !r_busy && r_cnt != '0)) begin
                        n_st = S_READ;
                    end else if (i_data.opcode == OP_PROC || i_data.opcode == OP_CMPL) begin
                        n_st = S_INFL;
                    end else begin
                        n_st = S_STAT;
                    end
                end
            end
            S_READ: begin
                if (r_cmd.opcode == OP_PROC) begin
                    if (out_free) begin
                        n_st = S_INFL;
                        out_load = 1'b1;
                    end
                end
                else if (r_i == r_cnt) n_st = S_INFL;
                else n_st = S_WALK;
            end
            S_WALK: begin
                if (hit) begin
                    if (out_free) begin
                        n_st = S_READ;
                        out_load = 1'b1;
                    end
                end else begin
                    wr_en = 1'b1;
                    wr_addr = wrap({1'b0, r_kept} + {{(CW+1-IW){1'b0}}, r_head});
                    wr_data = r_rd;
                    n_st = S_READ;
                end
            end
            S_INFL: begin
                if (out_free) begin
                    n_st = S_STAT;
                    out_load = inf_end;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_st = S_IDLE;
                    out_load = 1'b1;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_head <= '0;
            r_cnt <= '0;
            r_busy <= 1'b0;
            r_el <= '0;
            r_dtmo <= DEFAULT_TMO_RESET;
            r_ov <= 1'b0;
            r_i <= '0;
            r_kept <= '0;
            r_acc <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            r_st <= n_st;
            if (psel && penable && pwrite && paddr == 3'd0) begin
                r_dtmo <= pwdata[15:0];
            end
            if (out_load) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    r_i <= '0;
                    r_kept <= '0;
                    r_acc <= i_valid && i_data.opcode == OP_ENQ &&
                             r_cnt < CW'(QUEUE_DEPTH);
                    r_ovf <= i_valid && i_data.opcode == OP_ENQ &&
                             !(r_cnt < CW'(QUEUE_DEPTH));
                    if (i_valid) begin
                        r_cmd <= i_data;
                        if (i_data.opcode == OP_ENQ && r_cnt < CW'(QUEUE_DEPTH)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_data.opcode == OP_TICK && r_el != ELAPSED_MAX) begin
                            r_el <= r_el + 1'b1;
                        end
                    end
                end
                S_READ: begin
                    if (r_cmd.opcode == OP_PROC) begin
                        if (out_free) begin
                            r_inf <= r_rd;
                            r_busy <= 1'b1;
                            r_el <= '0;
                            r_head <= wrap({{(CW+1-IW){1'b0}}, r_head} + (CW+1)'(1));
                            r_cnt <= r_cnt - 1'b1;
                            r_acc <= 1'b1;
                            r_out <= '{KIND_ISSUE, r_rd.tag, r_rd.conn, r_rd.chr,
                                       r_rd.typ, 2'd0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
                            r_cmd.opcode <= OP_TICK;
                        end
                    end else if (r_i == r_cnt) begin
                        r_cnt <= r_kept;
                        r_i <= '0;
                    end
                end
                S_WALK: begin
                    if (hit) begin
                        if (out_free) begin
                            r_out <= '{KIND_NOTIFY, r_rd.tag, r_rd.conn, r_rd.chr,
                                       r_rd.typ, OUT_DISC, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_kept <= r_kept + 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_INFL: begin
                    if (out_free && inf_end) begin
                        r_busy <= 1'b0;
                        r_out <= '{KIND_NOTIFY, r_inf.tag, r_inf.conn, r_inf.chr,
                                   r_inf.typ,
                                   (r_cmd.opcode == OP_PROC) ? OUT_TIMEOUT :
                                   (r_cmd.opcode == OP_CMPL) ? r_cmd.result_code :
                                   OUT_DISC,
                                   1'b0, 1'b0, 5'd0, 1'b0, 1'b0};
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_out <= '{KIND_STATUS, 8'd0, 16'd0, 16'd0, 3'd0, 2'd0,
                                   r_acc, r_ovf, 5'(r_cnt), r_busy, 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: hw/rtl/socq_checker.sv
// ---------------------------------------------------------------------------
// socq_checker
// port-level checks of the command queue, bound into the queue module
// ---------------------------------------------------------------------------
`include "single_outstanding_command_queue_assert.svh"

module socq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input socq_pkg::t_out o_data
);
    import socq_pkg::*;

    `SOCQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `SOCQ_ASSERT_IMP(a_last, i_clk, i_rst_n, o_valid, o_data.last == (o_data.kind == KIND_STATUS))
    `SOCQ_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !(o_data.accepted && o_data.overflow))
    `SOCQ_ASSERT_IMP(a_cnt, i_clk, i_rst_n, o_valid && o_data.last, o_data.queue_count <= 5'd16)
endmodule

bind single_outstanding_command_queue socq_checker u_socq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

FILE: tb/single_outstanding_command_queue_test.sv
// ---------------------------------------------------------------------------
// single_outstanding_command_queue_test
// drives enqueue, process, complete, flush and tick commands into the queue,
// predicts every issue, notification and status transfer, and checks each
// output transfer field by field under idling, stalling and backpressure
// ---------------------------------------------------------------------------
module single_outstanding_command_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import socq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [2:0] ADDR_DEFAULT_TMO = 3'd0;
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    class queue_scoreboard;
        t_entry      store[DEPTH];
        int          head, count;
        bit          busy;
        t_entry      current;
        logic [16:0] elapsed;
        logic [15:0] dflt_tmo;
        t_out        expected[$];
        int          errors, commands, results, overflows, timeouts, cancels;

        function new();
            head = 0; count = 0; busy = 0; elapsed = 0;
            dflt_tmo = DEFAULT_TMO_RESET;
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results, what, got, want);
        endtask

        function void push_op(logic [1:0] kind, t_entry e, logic [1:0] outc);
            t_out r;
            r = '0;
            r.kind = kind; r.op_tag_res = e.tag; r.conn_out = e.conn;
            r.char_out = e.chr; r.type_out = e.typ; r.outcome = outc;
            expected.push_back(r);
        endfunction

        function void flush_ops(bit all, logic [15:0] conn);
            t_entry kept[$];
            t_entry e;
            for (int i = 0; i < count; i++) begin
                e = store[(head + i) % DEPTH];
                if (all || e.conn == conn) begin
                    push_op(KIND_NOTIFY, e, OUT_DISC);
                    cancels++;
                end else begin
                    kept.push_back(e);
                end
            end
            foreach (kept[i]) store[i] = kept[i];
            head = 0;
            count = kept.size();
            if (busy && (all || current.conn == conn)) begin
                push_op(KIND_NOTIFY, current, OUT_DISC);
                busy = 0;
                cancels++;
            end
        endfunction

        function void note_command(t_in c);
            t_entry e;
            t_out   s;
            bit     acc, ovf;
            acc = 0; ovf = 0;
            commands++;
            case (c.opcode)
                OP_ENQ: begin
                    e.tag = c.op_tag; e.conn = c.conn_id; e.chr = c.char_id;
                    e.typ = c.op_type;
                    e.tmo = (c.tmo_req == 0) ? dflt_tmo : c.tmo_req;
                    if (count < DEPTH) begin
                        store[(head + count) % DEPTH] = e;
                        count++;
                        acc = 1;
                    end else begin
                        ovf = 1;
                        overflows++;
                    end
                end
                OP_PROC: begin
                    if (busy) begin
                        if (elapsed > {1'b0, current.tmo}) begin
                            push_op(KIND_NOTIFY, current, OUT_TIMEOUT);
                            busy = 0;
                            timeouts++;
                        end
                    end else if (count > 0) begin
                        current = store[head];
                        head = (head + 1) % DEPTH;
                        count--;
                        busy = 1;
                        elapsed = 0;
                        push_op(KIND_ISSUE, current, 2'd0);
                        acc = 1;
                    end
                end
                OP_CMPL: begin
                    if (busy) begin
                        push_op(KIND_NOTIFY, current, c.result_code);
                        busy = 0;
                    end
                end
                OP_CLRC: flush_ops(0, c.conn_id);
                OP_CLRA: flush_ops(1, '0);
                OP_TICK: if (elapsed != ELAPSED_MAX) elapsed++;
                default: ;
            endcase
            s = '0;
            s.kind = KIND_STATUS; s.accepted = acc; s.overflow = ovf;
            s.queue_count = count[4:0]; s.busy_res = busy; s.last = 1'b1;
            expected.push_back(s);
        endfunction

        task check_result(t_out got);
            t_out w;
            results++;
            if (expected.size() == 0) begin
                report("unexpected transfer, kind", got.kind, 0);
                return;
            end
            w = expected.pop_front();
            if (got.kind !== w.kind) report("kind", got.kind, w.kind);
            if (got.op_tag_res !== w.op_tag_res) report("op_tag_res", got.op_tag_res, w.op_tag_res);
            if (got.conn_out !== w.conn_out) report("conn_out", got.conn_out, w.conn_out);
            if (got.char_out !== w.char_out) report("char_out", got.char_out, w.char_out);
            if (got.type_out !== w.type_out) report("type_out", got.type_out, w.type_out);
            if (got.outcome !== w.outcome) report("outcome", got.outcome, w.outcome);
            if (got.accepted !== w.accepted) report("accepted", got.accepted, w.accepted);
            if (got.overflow !== w.overflow) report("overflow", got.overflow, w.overflow);
            if (got.queue_count !== w.queue_count)
                report("queue_count", got.queue_count, w.queue_count);
            if (got.busy_res !== w.busy_res) report("busy_res", got.busy_res, w.busy_res);
            if (got.last !== w.last) report("last", got.last, w.last);
        endtask
    endclass

    logic        i_clk, i_rst_n, i_valid, i_stall;
    logic        o_stall, o_valid;
    t_in         i_data;
    t_out        o_data;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    queue_scoreboard sb;
    int send_idle_pct, stall_pct, hold_req;

    single_outstanding_command_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[single_outstanding_command_queue] ERROR");
        $finish;
    end

    // receiver with random stall and a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) hold_left--;
            i_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
        end
    end

    task send_cmd(t_in c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= c;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(c);
    endtask

    task write_default_tmo(logic [15:0] v);
        i_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_DEFAULT_TMO; pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.dflt_tmo = v;
    endtask

    function automatic t_in cmd(logic [2:0] op, logic [7:0] tag, logic [15:0] conn,
                                logic [2:0] typ, logic [15:0] tmo, logic [1:0] rc);
        t_in c;
        c.opcode = op; c.op_tag = tag; c.conn_id = conn;
        c.char_id = 16'($urandom);
        c.op_type = typ; c.tmo_req = tmo; c.result_code = rc;
        return c;
    endfunction

    function automatic t_in random_cmd();
        t_in c;
        int  r;
        c = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 36) c.opcode = OP_ENQ;
        else if (r < 60) c.opcode = OP_PROC;
        else if (r < 76) c.opcode = OP_TICK;
        else if (r < 88) c.opcode = OP_CMPL;
        else if (r < 94) c.opcode = OP_CLRC;
        else if (r < 97) c.opcode = OP_CLRA;
        else c.opcode = 3'($urandom_range(6, 7));
        if ($urandom_range(3) != 0) c.conn_id = 16'($urandom_range(3));
        r = $urandom_range(9);
        if (r < 2) c.tmo_req = '0;
        else if (r < 7) c.tmo_req = 16'($urandom_range(1, 6));
        return c;
    endfunction

    task random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) send_cmd(random_cmd());
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0; stall_pct = 0; hold_req = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every command, corner behavior
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_CMPL, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_ENQ, 8'hff, 16'hffff, 3'd5, 16'hffff, 2'd3));
        send_cmd(cmd(OP_ENQ, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_ENQ, 8'h5a, 16'h0001, 3'd7, 16'd1, 2'd0));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_TICK, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_CMPL, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd3));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_CMPL, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd1));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_TICK, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_TICK, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_UNUSED_LO, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_UNUSED_HI, 8'hff, 16'hffff, 3'd7, 16'hffff, 2'd3));
        send_cmd(cmd(OP_ENQ, 8'h11, 16'h0001, 3'd1, 16'd9, 2'd0));
        send_cmd(cmd(OP_ENQ, 8'h22, 16'h0002, 3'd2, 16'd9, 2'd0));
        send_cmd(cmd(OP_ENQ, 8'h33, 16'h0001, 3'd3, 16'd9, 2'd0));
        send_cmd(cmd(OP_PROC, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_CLRC, 8'h00, 16'h0001, 3'd0, 16'd0, 2'd0));
        send_cmd(cmd(OP_ENQ, 8'h44, 16'h0003, 3'd4, 16'd0, 2'd2));
        send_cmd(cmd(OP_CLRA, 8'h00, 16'h0000, 3'd0, 16'd0, 2'd0));

        // long receiver hold-off while enqueue commands keep being offered
        hold_req = 400;
        repeat (30) send_cmd(cmd(OP_ENQ, 8'($urandom), 16'($urandom_range(2)),
                                 3'($urandom), 16'($urandom_range(4)), 2'd0));
        random_phase(25, 0, 0);

        write_default_tmo(16'd1);
        random_phase(40, 67, 0);
        write_default_tmo(16'hffff);
        random_phase(40, 0, 67);
        write_default_tmo(16'd0);
        random_phase(25, 6, 6);
        write_default_tmo(16'($urandom_range(1, 65535)));
        random_phase(25, 6, 6);

        i_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d commands, %0d result transfers checked", sb.commands, sb.results);
        $display("%0d overflows, %0d timeouts, %0d flush cancels, %0d mismatches",
                 sb.overflows, sb.timeouts, sb.cancels, sb.errors);
        if (sb.errors == 0) begin
            $display("[single_outstanding_command_queue] OK");
        end else begin
            $display("[single_outstanding_command_queue] ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/socq_pkg.sv
hw/rtl/single_outstanding_command_queue.sv
hw/rtl/socq_checker.sv
tb/single_outstanding_command_queue_test.sv
